// File: hw/rtl/ips_pkg.sv
package ips_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int POS_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT0     = 8'h30;
    localparam logic [7:0] CH_DIGIT1     = 8'h31;
    localparam logic [7:0] CH_DIGIT9     = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [5:0] {
        MODE_IDLE     = 6'b000001,
        MODE_LIT      = 6'b000010,
        MODE_DOLLAR   = 6'b000100,
        MODE_BRACE    = 6'b001000,
        MODE_NAME     = 6'b010000,
        MODE_CAPCLOSE = 6'b100000
    } mode_t;

    typedef struct packed {
        pos_t part_start;
        pos_t part_end;
        logic is_variable;
        logic is_capture;
        logic last_part;
    } part_t;

    // One queue entry: every part found while scanning one byte
    typedef struct packed {
        part_t p0;
        part_t p1;
        logic  has_p1;
    } pair_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic pos_t sat_inc(input pos_t v);
        return (v >= POS_MAX) ? POS_MAX : v + pos_t'(1);
    endfunction

    function automatic logic is_name_byte(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
               (b >= CH_DIGIT0 && b <= CH_DIGIT9) || (b == CH_UNDERSCORE);
    endfunction

    function automatic part_t mk_part(input pos_t s, input pos_t e, input logic var_f,
                                      input logic cap_f, input logic last_f);
        part_t p;
        p.part_start  = s;
        p.part_end    = e;
        p.is_variable = var_f;
        p.is_capture  = cap_f;
        p.last_part   = last_f;
        return p;
    endfunction

endpackage

// File: hw/rtl/ips_front.sv
module ips_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     text_byte,
    input  logic           end_of_string,
    input  logic           accept,
    output logic           push,
    output ips_pkg::pair_t push_data
);
    import ips_pkg::*;

    mode_t mode_reg, mode_next;
    pos_t  pos_reg, pos_next;
    pos_t  start_reg, start_next;
    logic  brace_reg, brace_next;

    logic  a_v, b_v, sp, fv;
    part_t a_part, b_part;
    pos_t  inc_pos, inc_start;
    logic  eos, is_dollar, is_lbrace, is_rbrace, is_digit, is_name;

    assign eos       = end_of_string;
    assign inc_pos   = sat_inc(pos_reg);
    assign inc_start = sat_inc(start_reg);
    assign is_dollar = (text_byte == CH_DOLLAR);
    assign is_lbrace = (text_byte == CH_LBRACE);
    assign is_rbrace = (text_byte == CH_RBRACE);
    assign is_digit  = (text_byte >= CH_DIGIT1) && (text_byte <= CH_DIGIT9);
    assign is_name   = is_name_byte(text_byte);

    always_comb begin
        a_v        = 1'b0;
        b_v        = 1'b0;
        sp         = 1'b0;
        fv         = 1'b0;
        a_part     = mk_part(pos_reg, pos_reg, 1'b0, 1'b0, 1'b0);
        b_part     = a_part;
        mode_next  = mode_reg;
        start_next = start_reg;
        brace_next = brace_reg;

        unique case (mode_reg)
            MODE_LIT: begin
                if (is_dollar) begin
                    a_v    = 1'b1;
                    a_part = mk_part(start_reg, pos_reg, 1'b0, 1'b0, 1'b0);
                    sp     = 1'b1;
                end else if (eos) begin
                    mode_next = MODE_IDLE;
                    a_v       = 1'b1;
                    a_part    = mk_part(start_reg, inc_pos, 1'b0, 1'b0, 1'b1);
                end
            end
            MODE_DOLLAR: begin
                if (is_lbrace) begin
                    brace_next = 1'b1;
                    if (eos) begin
                        mode_next = MODE_IDLE;
                        a_v       = 1'b1;
                        a_part    = mk_part(inc_pos, inc_pos, 1'b1, 1'b0, 1'b1);
                    end else begin
                        mode_next = MODE_BRACE;
                    end
                end else begin
                    fv = 1'b1;
                end
            end
            MODE_BRACE: begin
                fv = 1'b1;
            end
            MODE_NAME: begin
                if (is_name) begin
                    if (eos) begin
                        mode_next = MODE_IDLE;
                        a_v       = 1'b1;
                        a_part    = mk_part(start_reg, inc_pos, 1'b1, 1'b0, 1'b1);
                    end
                end else if (brace_reg && is_rbrace) begin
                    mode_next = MODE_IDLE;
                    a_v       = 1'b1;
                    a_part    = mk_part(start_reg, pos_reg, 1'b1, 1'b0, eos);
                end else begin
                    a_v    = 1'b1;
                    a_part = mk_part(start_reg, pos_reg, 1'b1, 1'b0, 1'b0);
                    sp     = 1'b1;
                end
            end
            MODE_CAPCLOSE: begin
                if (is_rbrace) begin
                    mode_next = MODE_IDLE;
                    a_v       = 1'b1;
                    a_part    = mk_part(start_reg, inc_start, 1'b1, 1'b1, eos);
                end else begin
                    a_v    = 1'b1;
                    a_part = mk_part(start_reg, inc_start, 1'b1, 1'b1, 1'b0);
                    sp     = 1'b1;
                end
            end
            default: begin
                sp = 1'b1;
            end
        endcase

        // first byte after '$' or '${'
        if (fv) begin
            if (is_digit) begin
                start_next = pos_reg;
                if (brace_reg && !eos) begin
                    mode_next = MODE_CAPCLOSE;
                end else begin
                    mode_next = MODE_IDLE;
                    a_v       = 1'b1;
                    a_part    = mk_part(pos_reg, inc_pos, 1'b1, 1'b1, eos);
                end
            end else if (is_name) begin
                start_next = pos_reg;
                if (eos) begin
                    mode_next = MODE_IDLE;
                    a_v       = 1'b1;
                    a_part    = mk_part(pos_reg, inc_pos, 1'b1, 1'b0, 1'b1);
                end else begin
                    mode_next = MODE_NAME;
                end
            end else if (brace_reg && is_rbrace) begin
                mode_next = MODE_IDLE;
                a_v       = 1'b1;
                a_part    = mk_part(pos_reg, pos_reg, 1'b1, 1'b0, eos);
            end else begin
                // empty name: this byte opens the next part
                a_v    = 1'b1;
                a_part = mk_part(pos_reg, pos_reg, 1'b1, 1'b0, 1'b0);
                sp     = 1'b1;
            end
        end

        // current byte opens a new part
        if (sp) begin
            if (is_dollar) begin
                brace_next = 1'b0;
                if (eos) begin
                    mode_next = MODE_IDLE;
                    b_v       = 1'b1;
                    b_part    = mk_part(inc_pos, inc_pos, 1'b1, 1'b0, 1'b1);
                end else begin
                    mode_next = MODE_DOLLAR;
                end
            end else begin
                start_next = pos_reg;
                if (eos) begin
                    mode_next = MODE_IDLE;
                    b_v       = 1'b1;
                    b_part    = mk_part(pos_reg, inc_pos, 1'b0, 1'b0, 1'b1);
                end else begin
                    mode_next = MODE_LIT;
                end
            end
        end

        if (eos) begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            brace_next = 1'b0;
        end else begin
            pos_next = inc_pos;
        end
    end

    always_comb begin
        push_data.p0     = a_v ? a_part : b_part;
        push_data.p1     = b_part;
        push_data.has_p1 = a_v && b_v;
        push             = accept && (a_v || b_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            brace_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            brace_reg <= brace_next;
        end
    end

endmodule

// File: hw/rtl/ips_queue.sv
module ips_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ips_pkg::pair_t   push_data,
    input  logic             pop,
    output ips_pkg::pair_t   pop_data,
    output ips_pkg::q_stat_t stat
);
    import ips_pkg::*;

    pair_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/ips_back.sv
module ips_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  ips_pkg::pair_t   pop_data,
    input  ips_pkg::q_stat_t q_stat,
    output logic             pop,
    output ips_pkg::part_t   out_part,
    output logic             out_valid,
    input  logic             out_ready
);
    import ips_pkg::*;

    part_t out_reg, pend_reg;
    logic  out_valid_reg, pend_valid_reg;
    logic  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = out_free && !pend_valid_reg && !q_stat.empty;
    assign out_part  = out_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (!q_stat.empty) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= pop_data.has_p1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the second part of a pair until the first is taken
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
            end else if (!q_stat.empty) begin
                out_reg  <= pop_data.p0;
                pend_reg <= pop_data.p1;
            end
        end
    end

endmodule

// File: hw/rtl/interpolation_part_splitter_core.sv
// Interpolation part splitter.
// s_ channel: one string byte per transaction; s_tdata[7:0] is the byte and
//   s_tlast marks the final byte of the string.
// m_ channel: one part per transaction; m_tdata holds the start and end
//   offsets, m_tuser the variable and capture flags, m_tlast the final part.
// Each byte yields zero, one or two parts. A byte is taken every cycle while
// the four-entry part queue between the scanner and the output stage has
// room. A part passes from the byte that completes it through the queue and
// the output register to m_; two parts from one byte leave in order, and the
// output stage sends one part per cycle at most, while m_tready is high.
// Offsets count from the first byte of the string and saturate at 4096.
// When m_tready is low, parts collect in the queue; once it is full,
// s_tready falls and input stalls with no part lost.
// Reset (aresetn low, synchronous) empties the queue and the output stage
// and restarts scanning at offset zero; after s_tlast the scanner also
// restarts at offset zero.
module interpolation_part_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [31:0] m_tdata,   // [12:0] part_start, [25:13] part_end, zero fill
    output logic [1:0]  m_tuser,   // [0] is_variable, [1] is_capture
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import ips_pkg::*;

    logic    accept;
    logic    q_push, q_pop;
    pair_t   q_wdata, q_rdata;
    q_stat_t q_stat;
    part_t   out_part;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    ips_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .text_byte     (s_tdata),
        .end_of_string (s_tlast),
        .accept        (accept),
        .push          (q_push),
        .push_data     (q_wdata)
    );

    ips_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    ips_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_data  (q_rdata),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_part  (out_part),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'd0, out_part.part_end, out_part.part_start};
    assign m_tuser = {out_part.is_capture, out_part.is_variable};
    assign m_tlast = out_part.last_part;

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("part queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("part queue read while empty");

    a_last_byte_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> q_push)
        else $error("final byte produced no part");

    a_last_part_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_wdata.p0.last_part) |-> !q_wdata.has_p1)
        else $error("part follows the final part");
`endif

endmodule

// File: tb/interpolation_part_splitter_core_tb.sv
module interpolation_part_splitter_core_tb;
    import ips_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [7:0] CH_MINUS    = 8'h2D;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;

    interpolation_part_splitter_core uut (.*);

    // handshake shaping
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holdoff_left  = 0;

    // run bookkeeping
    int error_count   = 0;
    int parts_checked = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    int cycle_count   = 0;

    logic [7:0] text_buf[$];
    part_t      parts_due[$];
    part_t      part_want;

    // scanner state mirrored by the predictor
    mode_t scan_state;
    pos_t  scan_pos;
    pos_t  part_origin;
    logic  braced;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    //------------------------------------------------------------------
    // Part predictor
    //------------------------------------------------------------------
    function automatic pos_t pos_next(input pos_t v);
        if (v >= POS_MAX)
            return POS_MAX;
        return v + 13'd1;
    endfunction

    function automatic logic ident_char(input logic [7:0] b);
        logic upper, lower, digit;
        upper = (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
        lower = (b >= CH_LOWER_A) && (b <= CH_LOWER_Z);
        digit = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
        return upper || lower || digit || (b == CH_UNDERSCORE);
    endfunction

    task automatic queue_part(input pos_t s, input pos_t e, input logic v,
                              input logic c, input logic l);
        part_t p;
        p.part_start  = s;
        p.part_end    = e;
        p.is_variable = v;
        p.is_capture  = c;
        p.last_part   = l;
        parts_due.push_back(p);
    endtask

    // Byte b at offset pos opens a new part
    task automatic open_part(input logic [7:0] b, input pos_t pos, input logic eos);
        if (b == CH_DOLLAR) begin
            braced = 1'b0;
            if (eos) begin
                scan_state = MODE_IDLE;
                queue_part(pos_next(pos), pos_next(pos), 1'b1, 1'b0, 1'b1);
            end else begin
                scan_state = MODE_DOLLAR;
            end
        end else begin
            part_origin = pos;
            if (eos) begin
                scan_state = MODE_IDLE;
                queue_part(pos, pos_next(pos), 1'b0, 1'b0, 1'b1);
            end else begin
                scan_state = MODE_LIT;
            end
        end
    endtask

    // First byte after '$' or '${'
    task automatic after_dollar(input logic [7:0] b, input pos_t pos, input logic eos);
        if (b >= CH_DIGIT1 && b <= CH_DIGIT9) begin
            part_origin = pos;
            if (braced && !eos) begin
                scan_state = MODE_CAPCLOSE;
            end else begin
                scan_state = MODE_IDLE;
                queue_part(pos, pos_next(pos), 1'b1, 1'b1, eos);
            end
        end else if (ident_char(b)) begin
            part_origin = pos;
            if (eos) begin
                scan_state = MODE_IDLE;
                queue_part(pos, pos_next(pos), 1'b1, 1'b0, 1'b1);
            end else begin
                scan_state = MODE_NAME;
            end
        end else if (braced && b == CH_RBRACE) begin
            scan_state = MODE_IDLE;
            queue_part(pos, pos, 1'b1, 1'b0, eos);
        end else begin
            // empty name; this byte begins the next part
            queue_part(pos, pos, 1'b1, 1'b0, 1'b0);
            open_part(b, pos, eos);
        end
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic eos);
        pos_t pos;
        pos_t origin;
        pos    = scan_pos;
        origin = part_origin;
        case (scan_state)
            MODE_LIT: begin
                if (b == CH_DOLLAR) begin
                    queue_part(origin, pos, 1'b0, 1'b0, 1'b0);
                    open_part(b, pos, eos);
                end else if (eos) begin
                    scan_state = MODE_IDLE;
                    queue_part(origin, pos_next(pos), 1'b0, 1'b0, 1'b1);
                end
            end
            MODE_DOLLAR: begin
                if (b == CH_LBRACE) begin
                    braced = 1'b1;
                    if (eos) begin
                        scan_state = MODE_IDLE;
                        queue_part(pos_next(pos), pos_next(pos), 1'b1, 1'b0, 1'b1);
                    end else begin
                        scan_state = MODE_BRACE;
                    end
                end else begin
                    after_dollar(b, pos, eos);
                end
            end
            MODE_BRACE: after_dollar(b, pos, eos);
            MODE_NAME: begin
                if (ident_char(b)) begin
                    if (eos) begin
                        scan_state = MODE_IDLE;
                        queue_part(origin, pos_next(pos), 1'b1, 1'b0, 1'b1);
                    end
                end else if (braced && b == CH_RBRACE) begin
                    scan_state = MODE_IDLE;
                    queue_part(origin, pos, 1'b1, 1'b0, eos);
                end else begin
                    queue_part(origin, pos, 1'b1, 1'b0, 1'b0);
                    open_part(b, pos, eos);
                end
            end
            MODE_CAPCLOSE: begin
                if (b == CH_RBRACE) begin
                    scan_state = MODE_IDLE;
                    queue_part(origin, pos_next(origin), 1'b1, 1'b1, eos);
                end else begin
                    queue_part(origin, pos_next(origin), 1'b1, 1'b1, 1'b0);
                    open_part(b, pos, eos);
                end
            end
            default: open_part(b, pos, eos);
        endcase

        if (eos) begin
            scan_state  = MODE_IDLE;
            scan_pos    = '0;
            part_origin = '0;
            braced      = 1'b0;
        end else begin
            scan_pos = pos_next(pos);
        end
    endtask

    //------------------------------------------------------------------
    // Receiver and part checker
    //------------------------------------------------------------------
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            m_tready <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string field, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch on part %0d: expected %0d, actual %0d",
                     $time, field, parts_checked, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (parts_due.size() == 0) begin
                $display("%0t: part with nothing expected: tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                part_want = parts_due.pop_front();
                check_field("part_start", part_want.part_start, m_tdata[12:0]);
                check_field("part_end", part_want.part_end, m_tdata[25:13]);
                check_field("tdata fill", 13'd0, 13'(m_tdata[31:26]));
                check_field("is_variable", 13'(part_want.is_variable), 13'(m_tuser[0]));
                check_field("is_capture", 13'(part_want.is_capture), 13'(m_tuser[1]));
                check_field("last_part", 13'(part_want.last_part), 13'(m_tlast));
            end
            parts_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d parts outstanding",
                     cycle_count, parts_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Byte sender
    //------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(3, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // predict on the falling edge so the expectation is in place before any result
        @(negedge aclk);
        scan_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text;
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        strings_sent++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic send_str(input string s);
        text_buf.delete();
        push_str(s);
        send_text();
    endtask

    // Drop valid and hold until every queued part has come out
    task automatic wait_drain;
        s_tvalid <= 1'b0;
        while (parts_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    //------------------------------------------------------------------
    // Random string content
    //------------------------------------------------------------------
    function automatic logic [7:0] name_char;
        case ($urandom_range(3))
            0:       return CH_UPPER_A + 8'($urandom_range(25));
            1:       return CH_LOWER_A + 8'($urandom_range(25));
            2:       return CH_DIGIT0 + 8'($urandom_range(9));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] plain_char;
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_DOLLAR);
        return b;
    endfunction

    task automatic add_name(input int n);
        repeat (n) text_buf.push_back(name_char());
    endtask

    task automatic add_token;
        int kind;
        int n;
        kind = $urandom_range(19);
        if (kind <= 4) begin
            n = $urandom_range(6, 1);
            repeat (n) text_buf.push_back(plain_char());
        end else if (kind <= 7) begin
            text_buf.push_back(CH_DOLLAR);
            add_name($urandom_range(5, 1));
        end else if (kind <= 10) begin
            push_str("${");
            add_name($urandom_range(5, 1));
            text_buf.push_back(CH_RBRACE);
        end else if (kind <= 12) begin
            text_buf.push_back(CH_DOLLAR);
            text_buf.push_back(CH_DIGIT1 + 8'($urandom_range(8)));
        end else if (kind <= 14) begin
            push_str("${");
            text_buf.push_back(CH_DIGIT1 + 8'($urandom_range(8)));
            text_buf.push_back(CH_RBRACE);
        end else if (kind == 15) begin
            // brace left open
            push_str("${");
            if ($urandom_range(1))
                add_name($urandom_range(4, 1));
            else
                text_buf.push_back(CH_DIGIT1 + 8'($urandom_range(8)));
        end else if (kind == 16) begin
            text_buf.push_back(CH_DOLLAR);
        end else if (kind == 17) begin
            push_str("${");
        end else if (kind == 18) begin
            push_str("${}");
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) begin
                case ($urandom_range(5))
                    0:       text_buf.push_back(CH_DOLLAR);
                    1:       text_buf.push_back(CH_LBRACE);
                    2:       text_buf.push_back(CH_RBRACE);
                    default: text_buf.push_back(8'($urandom_range(255)));
                endcase
            end
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_directed_cases;
        send_idle_pct = 0;
        stall_pct     = 0;
        // dollar as final byte, after a zero byte
        send_byte(8'h00, 1'b0);
        send_byte(CH_DOLLAR, 1'b1);
        send_str("${");
        send_str("$-");
        send_str("${}");
        // open brace and a name, then a byte that is no name byte
        send_str("${z-");
        send_str("${5x");
        send_str("$1${9}");
        send_byte(8'hFF, 1'b1);
        send_str("$Z");
        wait_drain();
    endtask

    task automatic test_output_holdoff;
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_left  = 80;
        // every pair of bytes yields parts, so the queue fills and input stalls
        text_buf.delete();
        repeat (30) begin
            text_buf.push_back(CH_DOLLAR);
            text_buf.push_back(CH_MINUS);
        end
        send_text();
        wait_drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall, input int n_bytes);
        int first;
        int n_tokens;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        first         = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            text_buf.delete();
            n_tokens = $urandom_range(6, 1);
            repeat (n_tokens) add_token();
            send_text();
        end
        wait_drain();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        s_tvalid    = 1'b0;
        m_tready    = 1'b0;
        scan_state  = MODE_IDLE;
        scan_pos    = '0;
        part_origin = '0;
        braced      = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_output_holdoff();
        test_random_phase(0, 0, 300);
        test_random_phase(45, 0, 300);
        test_random_phase(0, 45, 300);
        test_random_phase(36, 36, 300);

        wait_drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings, checked %0d parts.",
                 bytes_sent, strings_sent, parts_checked);
        $display("Directed cases, output hold-off, four handshake mixes.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
